/* sv/wlncs_pkg.sv */
// ----------------------------------------------------------------------------
// wlncs_pkg
// shared types, widths and constants of the next-chunk selector
// ----------------------------------------------------------------------------
package wlncs_pkg;

  // number of chunks in one scan, range 2 to 256 (chunk indexes are CHUNK_W bits)
  localparam int CHUNK_COUNT = 256;

  // scan index must also hold CHUNK_COUNT itself (saturation value)
  localparam int SCAN_W = $clog2(CHUNK_COUNT + 1);

  localparam int CHUNK_W    = 8;
  localparam int USED_W     = 16;
  localparam int WEAR_W     = 16;
  localparam int FREE_W     = 16;
  localparam int PCT_W      = 7;
  localparam int WEIGHT_W   = 8;
  localparam int BEST_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // eligibility: used * PCT_SCALE < free_groups * limit_pct
  localparam int PCT_SCALE = 100;
  localparam int ELIG_W    = USED_W + PCT_W;
  // used term is divided by 32
  localparam int SPEED_SHIFT = 5;
  localparam int FAC_W       = WEIGHT_W + 1;
  localparam int SPROD_W     = USED_W + FAC_W;
  localparam int LIFE_W      = WEAR_W + 1;
  localparam int LPROD_W     = LIFE_W + FAC_W;
  // internal score: one bit above the widest term
  localparam int SCORE_W     = LPROD_W + 1;

  localparam int LIMIT_RESET = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUR_CHUNK  = 3'd0,
    REG_CUR_WEAR   = 3'd1,
    REG_FREE_GRP   = 3'd2,
    REG_LIMIT_PCT  = 3'd3,
    REG_SPEED_WGT  = 3'd4,
    REG_LIFE_WGT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [USED_W-1:0] chunk_used;
    logic [WEAR_W-1:0] chunk_wear;
    logic              last_chunk;
  } in_item_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] next_chunk;
    logic               used_fallback;
    logic [BEST_W-1:0]  best_score;
  } out_item_t;

  typedef struct packed {
    logic [CHUNK_W-1:0]  current_chunk;
    logic [WEAR_W-1:0]   current_wear;
    logic [FREE_W-1:0]   free_groups;
    logic [PCT_W-1:0]    limit_pct;
    logic [WEIGHT_W-1:0] speed_weight;
    logic [WEIGHT_W-1:0] life_weight;
  } cfg_t;

  // one scored chunk, handed from the scoring stage to the selector
  typedef struct packed {
    logic               cand;
    logic               elig;
    logic               last;
    logic [CHUNK_W-1:0] pick;
    logic [USED_W-1:0]  used;
    logic [SCORE_W-1:0] score;
  } score_rec_t;

endpackage

/* sv/wlncs_score.sv */
// ----------------------------------------------------------------------------
// wlncs_score
// input register, scan index and per-chunk scoring into the record register
// ----------------------------------------------------------------------------
module wlncs_score (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  wlncs_pkg::in_item_t    in_data,
  input  wlncs_pkg::cfg_t        cfg,
  output logic                   rec_valid,
  input  logic                   rec_ready,
  output wlncs_pkg::score_rec_t  rec
);
  import wlncs_pkg::*;

  logic              a_valid_r, a_valid_nxt;
  in_item_t          a_item_r;
  logic [SCAN_W-1:0] a_idx_r;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              b_valid_r, b_valid_nxt;
  score_rec_t        b_rec_r, b_rec_nxt;

  logic               in_acc, a_adv, b_adv, b_free;
  logic [ELIG_W-1:0]  used_x100, free_x_lim;
  logic [LIFE_W-1:0]  life;
  logic [FAC_W-1:0]   speed_fac, life_fac;
  logic [SPROD_W-1:0] speed_prod;
  logic [LPROD_W-1:0] life_prod;

  assign b_adv    = b_valid_r && rec_ready;
  assign b_free   = !b_valid_r || b_adv;
  assign a_adv    = a_valid_r && b_free;
  assign in_ready = !a_valid_r || a_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    scan_nxt = scan_r;
    if (in_acc) begin
      if (in_data.last_chunk) begin
        scan_nxt = '0;
      end else if (scan_r < SCAN_W'(CHUNK_COUNT)) begin
        scan_nxt = scan_r + SCAN_W'(1);
      end
    end
  end

  assign a_valid_nxt = in_acc || (a_valid_r && !a_adv);
  assign b_valid_nxt = a_adv || (b_valid_r && !b_adv);

  // scoring of the chunk held in the input register
  always_comb begin
    used_x100  = ELIG_W'(a_item_r.chunk_used) * ELIG_W'(PCT_SCALE);
    free_x_lim = ELIG_W'(cfg.free_groups) * ELIG_W'(cfg.limit_pct);
    if (a_item_r.chunk_wear < cfg.current_wear) begin
      life = {a_item_r.chunk_wear, 1'b0};
    end else begin
      life = LIFE_W'(a_item_r.chunk_wear) + LIFE_W'(cfg.current_wear);
    end
    speed_fac  = FAC_W'(cfg.speed_weight) + FAC_W'(1);
    life_fac   = FAC_W'(cfg.life_weight) + FAC_W'(1);
    speed_prod = SPROD_W'(a_item_r.chunk_used) * SPROD_W'(speed_fac);
    life_prod  = LPROD_W'(life) * LPROD_W'(life_fac);

    b_rec_nxt.cand  = (a_idx_r < SCAN_W'(CHUNK_COUNT))
                      && (32'(a_idx_r) != 32'(cfg.current_chunk));
    b_rec_nxt.elig  = used_x100 < free_x_lim;
    b_rec_nxt.last  = a_item_r.last_chunk;
    b_rec_nxt.pick  = CHUNK_W'(32'(a_idx_r));
    b_rec_nxt.used  = a_item_r.chunk_used;
    b_rec_nxt.score = SCORE_W'(speed_prod >> SPEED_SHIFT) + SCORE_W'(life_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      scan_r    <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      scan_r    <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_item_r <= in_data;
      a_idx_r  <= scan_r;
    end
    if (a_adv) begin
      b_rec_r <= b_rec_nxt;
    end
  end

  assign rec_valid = b_valid_r;
  assign rec       = b_rec_r;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= SCAN_W'(CHUNK_COUNT))
    else $error("scan index past chunk count");

  a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_chunk) |=> (scan_r == '0))
    else $error("scan index not restarted after last chunk");

  a_idx_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (a_valid_r && a_idx_r == $past(scan_r)))
    else $error("input register lost its scan index");

endmodule

/* sv/wlncs_select.sv */
// ----------------------------------------------------------------------------
// wlncs_select
// running best-score and fewest-used tracking, result register
// ----------------------------------------------------------------------------
module wlncs_select (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rec_valid,
  output logic                   rec_ready,
  input  wlncs_pkg::score_rec_t  rec,
  input  logic [wlncs_pkg::CHUNK_W-1:0] current_chunk,
  output logic                   out_valid,
  input  logic                   out_ready,
  output wlncs_pkg::out_item_t   out_data
);
  import wlncs_pkg::*;

  logic               sfound_r, sfound_nxt;
  logic [SCORE_W-1:0] sbest_r, sbest_nxt;
  logic [CHUNK_W-1:0] spick_r, spick_nxt;
  logic               ffound_r, ffound_nxt;
  logic [USED_W-1:0]  fused_r, fused_nxt;
  logic [CHUNK_W-1:0] fpick_r, fpick_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic take, sc_upd, fw_upd;

  // a last record needs the result register free
  assign rec_ready = !rec.last || !out_valid_r || out_ready;
  assign take      = rec_valid && rec_ready;

  always_comb begin
    sc_upd = rec.cand && rec.elig && (!sfound_r || rec.score < sbest_r);
    fw_upd = rec.cand && (!ffound_r || rec.used < fused_r);

    sfound_nxt = sfound_r || sc_upd;
    sbest_nxt  = sc_upd ? rec.score : sbest_r;
    spick_nxt  = sc_upd ? rec.pick  : spick_r;
    ffound_nxt = ffound_r || fw_upd;
    fused_nxt  = fw_upd ? rec.used  : fused_r;
    fpick_nxt  = fw_upd ? rec.pick  : fpick_r;

    if (sfound_nxt) begin
      out_nxt.next_chunk    = spick_nxt;
      out_nxt.used_fallback = 1'b0;
      out_nxt.best_score    = BEST_W'(sbest_nxt);
    end else if (ffound_nxt) begin
      out_nxt.next_chunk    = fpick_nxt;
      out_nxt.used_fallback = 1'b1;
      out_nxt.best_score    = BEST_W'(fused_nxt);
    end else begin
      out_nxt.next_chunk    = current_chunk;
      out_nxt.used_fallback = 1'b1;
      out_nxt.best_score    = '0;
    end

    out_valid_nxt = (out_valid_r && !out_ready) || (take && rec.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sfound_r    <= 1'b0;
      sbest_r     <= '0;
      spick_r     <= '0;
      ffound_r    <= 1'b0;
      fused_r     <= '0;
      fpick_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (rec.last) begin
          sfound_r <= 1'b0;
          sbest_r  <= '0;
          spick_r  <= '0;
          ffound_r <= 1'b0;
          fused_r  <= '0;
          fpick_r  <= '0;
        end else begin
          sfound_r <= sfound_nxt;
          sbest_r  <= sbest_nxt;
          spick_r  <= spick_nxt;
          ffound_r <= ffound_nxt;
          fused_r  <= fused_nxt;
          fpick_r  <= fpick_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && rec.last) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_found_order: assert property (@(posedge clk) disable iff (!rst_n)
    sfound_r |-> ffound_r)
    else $error("eligible chunk seen without a fallback candidate");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && rec.last) |=> (!sfound_r && !ffound_r))
    else $error("tracking state not cleared after last chunk");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (take && rec.last) |=> out_valid_r)
    else $error("result missing after last chunk");

endmodule

/* sv/wear_leveling_next_chunk_select.sv */
// ----------------------------------------------------------------------------
// wear_leveling_next_chunk_select
// picks the next flash chunk to write from a stream of chunk records
// ----------------------------------------------------------------------------
//
//  channel   ports                          moves
//  --------  -----------------------------  ------------------------------------
//  input     in_valid  in_ready  in_data    one chunk record (used, wear, last)
//  result    out_valid out_ready out_data   chosen chunk, fallback flag, score
//  config    cfg_valid cfg_ready cfg_index  one register write (cfg_data)
//
//  one chunk record per cycle, sustained; a record passes to the result through
//  the input register, the score register and the result register
//  reset (synchronous, active low) restores the register defaults and starts
//  a fresh scan at chunk index 0; config is always ready
//  a stalled result only holds back a record that closes a scan: records in
//  the middle of a scan keep flowing into the tracking registers
//
module wear_leveling_next_chunk_select (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wlncs_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wlncs_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wlncs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wlncs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wlncs_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // record from the scoring stage to the selector
  logic       rec_valid;
  logic       rec_ready;
  score_rec_t rec;

  // writes must land only while idle (the user's duty, not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_chunk <= '0;
      cfg_r.current_wear  <= '0;
      cfg_r.free_groups   <= '0;
      cfg_r.limit_pct     <= PCT_W'(LIMIT_RESET);
      cfg_r.speed_weight  <= '0;
      cfg_r.life_weight   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CUR_CHUNK: begin
          cfg_r.current_chunk <= cfg_data[CHUNK_W-1:0];
        end
        REG_CUR_WEAR: begin
          cfg_r.current_wear <= cfg_data[WEAR_W-1:0];
        end
        REG_FREE_GRP: begin
          cfg_r.free_groups <= cfg_data[FREE_W-1:0];
        end
        REG_LIMIT_PCT: begin
          cfg_r.limit_pct <= cfg_data[PCT_W-1:0];
        end
        REG_SPEED_WGT: begin
          cfg_r.speed_weight <= cfg_data[WEIGHT_W-1:0];
        end
        REG_LIFE_WGT: begin
          cfg_r.life_weight <= cfg_data[WEIGHT_W-1:0];
        end
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // eligibility test and score of each chunk
  wlncs_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // lowest score / fewest used tracking and the result register
  wlncs_select u_select (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (rec_valid),
    .rec_ready     (rec_ready),
    .rec           (rec),
    .current_chunk (cfg_r.current_chunk),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives chunk records, register writes and result back-pressure into the
// next-chunk selector and compares every result with an in-bench prediction
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wlncs_pkg::*;

  // three register stages from input transaction to result
  localparam int PIPE_LATENCY = 3;
  localparam int TOTAL_ITEMS  = 1550;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_SCANS   = 3;

  // register indexes beyond the list, writes to them change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // --------------------------------------------------------------------------
  // predictor and store of expected choices
  // --------------------------------------------------------------------------
  class chunk_pick_board;
    // register copy
    logic [CHUNK_W-1:0]  cur_chunk;
    logic [WEAR_W-1:0]   cur_wear;
    logic [FREE_W-1:0]   free_grp;
    logic [PCT_W-1:0]    limit_pct;
    logic [WEIGHT_W-1:0] speed_wgt;
    logic [WEIGHT_W-1:0] life_wgt;
    // scan progress
    int unsigned         scan_pos;
    logic [BEST_W-1:0]   lowest_score;
    int unsigned         score_idx;
    bit                  score_seen;
    logic [USED_W-1:0]   lowest_used;
    int unsigned         used_idx;
    bit                  used_seen;
    out_item_t           pending[$];
    int                  errors;

    function new();
      cur_chunk = '0;
      cur_wear  = '0;
      free_grp  = '0;
      limit_pct = PCT_W'(LIMIT_RESET);
      speed_wgt = '0;
      life_wgt  = '0;
      errors    = 0;
      restart_scan();
    endfunction

    function void restart_scan();
      scan_pos     = 0;
      lowest_score = '0;
      score_idx    = 0;
      score_seen   = 1'b0;
      lowest_used  = '0;
      used_idx     = 0;
      used_seen    = 1'b0;
    endfunction

    // register write, data wider than the register is cut to its width
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CUR_CHUNK: cur_chunk = data[CHUNK_W-1:0];
        REG_CUR_WEAR:  cur_wear  = data[WEAR_W-1:0];
        REG_FREE_GRP:  free_grp  = data[FREE_W-1:0];
        REG_LIMIT_PCT: limit_pct = data[PCT_W-1:0];
        REG_SPEED_WGT: speed_wgt = data[WEIGHT_W-1:0];
        REG_LIFE_WGT:  life_wgt  = data[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_record(in_item_t rec);
      logic [63:0] lhs;
      logic [63:0] rhs;
      logic [63:0] life;
      logic [63:0] score;
      out_item_t   pick;
      // chunks past the chunk count and the current chunk take no part
      if (scan_pos < CHUNK_COUNT && scan_pos != cur_chunk) begin
        lhs = 64'(rec.chunk_used) * PCT_SCALE;
        rhs = 64'(free_grp) * 64'(limit_pct);
        if (lhs < rhs) begin
          if (rec.chunk_wear < cur_wear) begin
            life = 64'(rec.chunk_wear) * 2;
          end else begin
            life = 64'(rec.chunk_wear) + 64'(cur_wear);
          end
          score = ((64'(rec.chunk_used) * (64'(speed_wgt) + 1)) >> SPEED_SHIFT)
                  + life * (64'(life_wgt) + 1);
          if (!score_seen || score[BEST_W-1:0] < lowest_score) begin
            lowest_score = score[BEST_W-1:0];
            score_idx    = scan_pos;
            score_seen   = 1'b1;
          end
        end
        if (!used_seen || rec.chunk_used < lowest_used) begin
          lowest_used = rec.chunk_used;
          used_idx    = scan_pos;
          used_seen   = 1'b1;
        end
      end
      if (scan_pos < CHUNK_COUNT) scan_pos++;
      if (rec.last_chunk) begin
        if (score_seen) begin
          pick.next_chunk    = score_idx[CHUNK_W-1:0];
          pick.used_fallback = 1'b0;
          pick.best_score    = lowest_score;
        end else if (used_seen) begin
          pick.next_chunk    = used_idx[CHUNK_W-1:0];
          pick.used_fallback = 1'b1;
          pick.best_score    = BEST_W'(lowest_used);
        end else begin
          pick.next_chunk    = cur_chunk;
          pick.used_fallback = 1'b1;
          pick.best_score    = '0;
        end
        pending.push_back(pick);
        restart_scan();
      end
    endfunction

    task report(string what, logic [BEST_W-1:0] got, logic [BEST_W-1:0] want);
      $display("mismatch: %s got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending, chunk", BEST_W'(got.next_chunk), '0);
      end else begin
        want = pending.pop_front();
        if (got.next_chunk !== want.next_chunk)
          report("next_chunk", BEST_W'(got.next_chunk), BEST_W'(want.next_chunk));
        if (got.used_fallback !== want.used_fallback)
          report("used_fallback", BEST_W'(got.used_fallback),
                 BEST_W'(want.used_fallback));
        if (got.best_score !== want.best_score)
          report("best_score", got.best_score, want.best_score);
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  chunk_pick_board board = new();
  int unsigned     cycle_count = 0;
  int unsigned     items_sent  = 0;

  always #10 clk = ~clk;

  wear_leveling_next_chunk_select uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result monitor, values seen here are the ones of the edge itself
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // zero, the top of the range or anything between
  function automatic int unsigned pick_extreme(int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  function automatic in_item_t make_rec(int unsigned used, int unsigned wear, bit last);
    in_item_t rec;
    rec.chunk_used = used[USED_W-1:0];
    rec.chunk_wear = wear[WEAR_W-1:0];
    rec.last_chunk = last;
    return rec;
  endfunction

  // one input transaction, valid stays up when no gap follows
  task automatic send_record(in_item_t rec, int unsigned gap);
    in_valid <= 1'b1;
    in_data  <= rec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_record(rec);
    items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one register write, the block is idle whenever this runs
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop the record stream and let the pipeline empty out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // new register setting, narrow registers get random upper data bits
  task automatic randomise_config();
    int unsigned v;
    if ($urandom_range(0, 2) == 0) v = $urandom_range(0, 255);
    else v = pick_extreme(15);
    if ($urandom_range(0, 9) == 0) v = 255;
    write_reg(REG_CUR_CHUNK, CFG_DATA_W'(($urandom & 16'hff00) | v));
    write_reg(REG_CUR_WEAR, CFG_DATA_W'(pick_extreme(65535)));
    if ($urandom_range(0, 2) == 0) v = pick_extreme(2000);
    else v = pick_extreme(65535);
    write_reg(REG_FREE_GRP, CFG_DATA_W'(v));
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 100;
      2:       v = $urandom_range(101, 127);
      default: v = $urandom_range(0, 100);
    endcase
    write_reg(REG_LIMIT_PCT, CFG_DATA_W'(($urandom & 16'hff80) | v));
    write_reg(REG_SPEED_WGT, CFG_DATA_W'(($urandom & 16'hff00) | pick_extreme(255)));
    write_reg(REG_LIFE_WGT, CFG_DATA_W'(($urandom & 16'hff00) | pick_extreme(255)));
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  // used count aimed around the eligibility threshold of the present setting
  function automatic int unsigned pick_used();
    int unsigned thr;
    thr = (int'(board.free_grp) * int'(board.limit_pct)) / PCT_SCALE;
    if (thr > 65535) thr = 65535;
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(0, 65535);
      2, 3:    return (thr < 2) ? $urandom_range(0, 3) : $urandom_range(thr - 2, thr + 2);
      4:       return 0;
      5:       return 65535;
      default: return $urandom_range(0, thr);
    endcase
  endfunction

  function automatic int unsigned pick_wear();
    int unsigned cw;
    cw = board.cur_wear;
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return cw;
      3:       return (cw == 0) ? 1 : cw - 1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic run_scan(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_record(make_rec(pick_used(), pick_wear(), i == len - 1), pick_gap());
    end
  endtask

  // --------------------------------------------------------------------------
  // back-pressure on the result side: runs of ready broken by stalls,
  // sometimes long stretches with no stall at all
  // --------------------------------------------------------------------------
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) run_len = $urandom_range(50, 200);
      else run_len = $urandom_range(1, 20);
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned long_left;
    int unsigned n_scans;
    int unsigned len;
    long_left = LONG_SCANS;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: a lone record at the current chunk leaves no candidate
    send_record(make_rec(0, 0, 1'b1), pick_gap());
    // nothing eligible with no free groups, fewest used with a tie
    send_record(make_rec(5, 7, 1'b0), pick_gap());
    send_record(make_rec(3, 1, 1'b0), pick_gap());
    send_record(make_rec(3, 9, 1'b0), pick_gap());
    send_record(make_rec(65535, 65535, 1'b1), pick_gap());
    wait_drained();

    // top weights and limit: wear below, equal and above, score tie,
    // a used count right on the threshold, and the current chunk skipped
    write_reg(REG_CUR_CHUNK, 2);
    write_reg(REG_CUR_WEAR, 1000);
    write_reg(REG_FREE_GRP, 65535);
    write_reg(REG_LIMIT_PCT, 100);
    write_reg(REG_SPEED_WGT, 255);
    write_reg(REG_LIFE_WGT, 255);
    send_record(make_rec(100, 999, 1'b0), pick_gap());
    send_record(make_rec(100, 1000, 1'b0), pick_gap());
    send_record(make_rec(0, 0, 1'b0), pick_gap());
    send_record(make_rec(65535, 65535, 1'b0), pick_gap());
    send_record(make_rec(100, 999, 1'b0), pick_gap());
    send_record(make_rec(65534, 65535, 1'b1), pick_gap());
    wait_drained();

    // limit above a hundred from wide data, spare indexes, zero weights
    write_reg(REG_CUR_CHUNK, 16'hff);
    write_reg(REG_CUR_WEAR, 16'hffff);
    write_reg(REG_FREE_GRP, 16'h0001);
    write_reg(REG_LIMIT_PCT, 16'hffff);
    write_reg(REG_SPEED_WGT, 16'h0000);
    write_reg(REG_LIFE_WGT, 16'h0000);
    write_reg(REG_SPARE_LO, 16'hffff);
    write_reg(REG_SPARE_HI, 16'h5a5a);
    send_record(make_rec(1, 65535, 1'b0), pick_gap());
    send_record(make_rec(0, 65534, 1'b0), pick_gap());
    send_record(make_rec(0, 0, 1'b0), pick_gap());
    send_record(make_rec(65535, 0, 1'b1), pick_gap());
    wait_drained();

    // random phases: new setting, then a few scans, mostly short, at most
    // LONG_SCANS of them long, around or past the chunk count
    while (items_sent < TOTAL_ITEMS) begin
      randomise_config();
      n_scans = $urandom_range(1, 6);
      for (int unsigned s = 0; s < n_scans; s++) begin
        if (long_left > 0 && $urandom_range(0, 24) == 0) begin
          len = $urandom_range(CHUNK_COUNT - 6, CHUNK_COUNT + 40);
          long_left--;
        end else begin
          len = $urandom_range(1, 24);
        end
        run_scan(len);
      end
      wait_drained();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
sv/wlncs_pkg.sv
sv/wlncs_score.sv
sv/wlncs_select.sv
sv/wear_leveling_next_chunk_select.sv
verif/testbench.sv
